// ===== rtl/ssnr_pkg.sv =====
package ssnr_pkg;

  // table geometry
  localparam int TableEntries = 16;
  localparam int TblIdxW      = $clog2(TableEntries);

  // header checks
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [13:0] MinFrameLen   = 14'd34;

  // sum of the seven header words that do not depend on the lookup
  localparam int BaseSumW = 19;
  // base sum plus the two words of the new source address
  localparam int FullSumW = 20;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_PACKET = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  entry_index;
    logic [31:0] entry_key;
    logic [31:0] entry_value;
    logic        entry_valid;
    logic [13:0] frame_length;
    logic [15:0] ether_type;
    logic [63:0] ip_bytes_0_to_7;
    logic [31:0] ip_ttl_proto_check;
    logic [31:0] ip_src_addr;
    logic [31:0] ip_dst_addr;
  } ssnr_in_t;

  typedef struct packed {
    logic        verdict;
    logic [31:0] new_src_addr;
    logic [15:0] new_checksum;
  } ssnr_out_t;

  // table write request
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    logic [31:0] key;
    logic [31:0] value;
    logic        valid;
  } ssnr_wr_t;

  // ones' complement partial sum of header words 0..4 and the destination address
  function automatic logic [BaseSumW-1:0] ssnr_base_sum(input ssnr_in_t item);
    logic [BaseSumW-1:0] s;
    s = BaseSumW'(item.ip_bytes_0_to_7[63:48])
      + BaseSumW'(item.ip_bytes_0_to_7[47:32])
      + BaseSumW'(item.ip_bytes_0_to_7[31:16])
      + BaseSumW'(item.ip_bytes_0_to_7[15:0])
      + BaseSumW'(item.ip_ttl_proto_check[31:16])
      + BaseSumW'(item.ip_dst_addr[31:16])
      + BaseSumW'(item.ip_dst_addr[15:0]);
    return s;
  endfunction

endpackage

// ===== rtl/ssnr_table.sv =====
module ssnr_table import ssnr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ssnr_wr_t                wr_i,
  input  logic [31:0]             lookup_addr_i,
  output logic [TableEntries-1:0] hit_o,
  input  logic [TableEntries-1:0] sel_i,
  output logic [31:0]             sel_value_o
);

  logic [31:0]             key_q   [TableEntries];
  logic [31:0]             value_q [TableEntries];
  logic [TableEntries-1:0] valid_q;
  logic                    wr_in_range;

  assign wr_in_range = wr_i.en && (int'(wr_i.idx) < TableEntries);

  // slot in use flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_in_range) begin
      valid_q[wr_i.idx[TblIdxW-1:0]] <= wr_i.valid;
    end
  end

  // key and value storage, only read behind a valid bit
  always_ff @(posedge clk_i) begin
    if (wr_in_range) begin
      key_q[wr_i.idx[TblIdxW-1:0]]   <= wr_i.key;
      value_q[wr_i.idx[TblIdxW-1:0]] <= wr_i.value;
    end
  end

  // parallel exact match
  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      hit_o[i] = valid_q[i] && (key_q[i] == lookup_addr_i);
    end
  end

  // and-or read of the one-hot selected slot
  always_comb begin
    sel_value_o = '0;
    for (int i = 0; i < TableEntries; i++) begin
      sel_value_o = sel_value_o | (value_q[i] & {32{sel_i[i]}});
    end
  end

endmodule

// ===== rtl/static_source_nat_rewrite_core.sv =====
// a packet item's result is offered from the output register, after stages 1 to 3
// throughput: one item per cycle unless the output stalls; a load is held off while
// a packet sits in the match stage, so the packet reads the table as it stood when accepted
// load items give no result; a stall on the output backs up through the four stages
// reset: all stage valid bits cleared and the translation table emptied
module static_source_nat_rewrite_core import ssnr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ssnr_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ssnr_out_t out_item_o
);

  logic in_is_pkt;
  logic pkt_acc;
  logic load_acc;
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic out_ready;

  ssnr_wr_t                wr;
  logic [TableEntries-1:0] lookup_hit;
  logic [TableEntries-1:0] sel_onehot;
  logic [31:0]             sel_value;

  // stage 1: match vector, header checks, base sum
  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_ok_q;
  logic [TableEntries-1:0] s1_hit_q;
  logic [BaseSumW-1:0]     s1_sum_q;

  // stage 2: selected address
  logic                s2_valid_q, s2_valid_d;
  logic                s2_pass_q;
  logic [31:0]         s2_value_q;
  logic [BaseSumW-1:0] s2_sum_q;

  // stage 3: first fold
  logic                s3_valid_q, s3_valid_d;
  logic                s3_pass_q;
  logic [31:0]         s3_value_q;
  logic [16:0]         s3_fold_q;
  logic [FullSumW-1:0] full_sum;
  logic [16:0]         fold1;

  // output register
  logic        out_valid_q, out_valid_d;
  ssnr_out_t   out_item_q;
  logic [16:0] fold2;

  // handshake and hazard on table writes
  assign in_is_pkt  = (in_item_i.cmd == CMD_PACKET);
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s3_ready   = !s3_valid_q || out_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = in_is_pkt ? !s1_ready : s1_valid_q;
  assign pkt_acc    = in_valid_i && !in_stall_o && in_is_pkt;
  assign load_acc   = in_valid_i && !in_stall_o && !in_is_pkt;

  // table write from load items
  always_comb begin
    wr.en    = load_acc;
    wr.idx   = in_item_i.entry_index;
    wr.key   = in_item_i.entry_key;
    wr.value = in_item_i.entry_value;
    wr.valid = in_item_i.entry_valid;
  end

  // lowest matching slot wins
  assign sel_onehot = s1_hit_q & (~s1_hit_q + TableEntries'(1));

  ssnr_table u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (wr),
    .lookup_addr_i (in_item_i.ip_src_addr),
    .hit_o         (lookup_hit),
    .sel_i         (sel_onehot),
    .sel_value_o   (sel_value)
  );

  // checksum folds
  assign full_sum = FullSumW'(s2_sum_q) + FullSumW'(s2_value_q[31:16])
                  + FullSumW'(s2_value_q[15:0]);
  assign fold1    = 17'(full_sum[FullSumW-1:16]) + 17'(full_sum[15:0]);
  assign fold2    = 17'(s3_fold_q[16]) + 17'(s3_fold_q[15:0]);

  // stage valid bits
  always_comb begin
    s1_valid_d  = s1_ready ? pkt_acc : s1_valid_q;
    s2_valid_d  = s2_ready ? s1_valid_q : s2_valid_q;
    s3_valid_d  = s3_ready ? s2_valid_q : s3_valid_q;
    out_valid_d = out_ready ? s3_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      s3_valid_q  <= s3_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (pkt_acc) begin
      s1_ok_q  <= (in_item_i.ether_type == EtherTypeIpv4)
                  && (in_item_i.frame_length >= MinFrameLen);
      s1_hit_q <= lookup_hit;
      s1_sum_q <= ssnr_base_sum(in_item_i);
    end
    if (s1_valid_q && s2_ready) begin
      s2_pass_q  <= s1_ok_q && (|s1_hit_q);
      s2_value_q <= sel_value;
      s2_sum_q   <= s1_sum_q;
    end
    if (s2_valid_q && s3_ready) begin
      s3_pass_q  <= s2_pass_q;
      s3_value_q <= s2_value_q;
      s3_fold_q  <= fold1;
    end
    if (s3_valid_q && out_ready) begin
      if (s3_pass_q) begin
        out_item_q.verdict      <= 1'b1;
        out_item_q.new_src_addr <= s3_value_q;
        out_item_q.new_checksum <= ~fold2[15:0];
      end else begin
        out_item_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
